@@ rtl/ilss_pkg.sv @@
// Shared types, codes and constants for the light sensor read sequencer.
package ilss_pkg;

  localparam int AddrW   = 7;
  localparam int ByteW   = 8;
  localparam int CmdW    = 3;
  localparam int PctW    = 7;
  localparam int PhaseW  = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 8;
  localparam int InDataW  = 16;
  localparam int OutDataW = 32;

  localparam logic [AddrW-1:0] SENSOR_ADDRESS_RST = 7'd35;
  localparam logic [ByteW-1:0] MODE_OPCODE_RST    = 8'h10;

  localparam logic [CfgIdxW-1:0] REG_SENSOR_ADDRESS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MODE_OPCODE    = 1'd1;

  localparam logic [CmdW-1:0] CMD_NONE     = 3'd0;
  localparam logic [CmdW-1:0] CMD_CONTINUE = 3'd1;
  localparam logic [CmdW-1:0] CMD_ACK      = 3'd2;
  localparam logic [CmdW-1:0] CMD_STOP     = 3'd3;
  localparam logic [CmdW-1:0] CMD_RELEASE  = 3'd4;

  localparam logic [ByteW-1:0] ST_START      = 8'h08;
  localparam logic [ByteW-1:0] ST_RESTART    = 8'h10;
  localparam logic [ByteW-1:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [ByteW-1:0] ST_DATA_ACK   = 8'h28;
  localparam logic [ByteW-1:0] ST_DATA_NACK  = 8'h30;
  localparam logic [ByteW-1:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [ByteW-1:0] ST_RXDATA_ACK = 8'h50;

  localparam logic [PhaseW-1:0] PH_MODE  = 2'd0;
  localparam logic [PhaseW-1:0] PH_HIGH  = 2'd1;
  localparam logic [PhaseW-1:0] PH_LOW   = 2'd2;
  localparam logic [PhaseW-1:0] PH_CLOSE = 2'd3;

  localparam logic [ByteW-1:0] LEVEL_DARK = 8'd255;
  localparam logic [ByteW-1:0] LEVEL_DIM  = 8'd215;
  localparam logic [ByteW-1:0] TOP3_MASK  = 8'hE0;
  localparam logic [PctW-1:0]  PCT_FULL   = 7'd100;
  // x/10 == (x*205)>>11 for all 8-bit x
  localparam logic [ByteW-1:0] DIV10_MUL  = 8'd205;
  localparam int               DIV10_SHR  = 11;

  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] bus_status;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             drive_valid;
    logic [ByteW-1:0] drive_byte;
    logic [CmdW-1:0]  bus_command;
    logic             error_flag;
    logic             sample_done;
    logic [ByteW-1:0] led_level;
    logic [PctW-1:0]  level_percent;
  } result_t;

endpackage

@@ rtl/ilss_level.sv @@
// Brightness level and percentage from the high and low reading bytes.
module ilss_level (
  input  logic [ilss_pkg::ByteW-1:0] hi,
  input  logic [ilss_pkg::ByteW-1:0] lo,
  output logic [ilss_pkg::ByteW-1:0] level,
  output logic [ilss_pkg::PctW-1:0]  percent
);

  logic [2*ilss_pkg::ByteW-1:0] prod;
  logic [4:0]                   tens;

  always_comb begin
    priority if (hi == '0 && (lo & ilss_pkg::TOP3_MASK) == '0) begin
      level = ilss_pkg::LEVEL_DARK;
    end else if ((hi & ilss_pkg::TOP3_MASK) == '0) begin
      level = ilss_pkg::LEVEL_DIM;
    end else begin
      level = ilss_pkg::LEVEL_DARK - hi;
    end
  end

  assign prod    = level * ilss_pkg::DIV10_MUL;
  assign tens    = prod[2*ilss_pkg::ByteW-1:ilss_pkg::DIV10_SHR];
  assign percent = ilss_pkg::PCT_FULL - {tens, 2'b00};

endmodule

@@ rtl/ilss_step.sv @@
// Phase tracking, status checking and result forming for one word.
module ilss_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  ilss_pkg::item_t             item,
  input  logic [ilss_pkg::AddrW-1:0]  sensor_address,
  input  logic [ilss_pkg::ByteW-1:0]  mode_opcode,
  output ilss_pkg::result_t           res
);

  logic [ilss_pkg::PhaseW-1:0] phase, phase_next;
  logic                        sticky_error, sticky_error_next;
  logic [ilss_pkg::ByteW-1:0]  high_reading, high_reading_next;
  logic [ilss_pkg::ByteW-1:0]  level;
  logic [ilss_pkg::PctW-1:0]   percent;
  logic                        bad;

  ilss_level u_level (
    .hi      (high_reading),
    .lo      (item.rx_byte),
    .level   (level),
    .percent (percent)
  );

  always_comb begin
    res               = '0;
    phase_next        = phase;
    sticky_error_next = sticky_error;
    high_reading_next = high_reading;
    bad               = 1'b0;
    if (!item.op) begin
      sticky_error_next = 1'b0;
    end else if (phase == ilss_pkg::PH_CLOSE) begin
      phase_next      = ilss_pkg::PH_MODE;
      res.bus_command = ilss_pkg::CMD_RELEASE;
    end else begin
      unique case (item.bus_status)
        ilss_pkg::ST_START: begin
          if (phase == ilss_pkg::PH_MODE) begin
            res.drive_valid = 1'b1;
            res.drive_byte  = {sensor_address, 1'b0};
            res.bus_command = ilss_pkg::CMD_CONTINUE;
          end else begin
            bad = 1'b1;
          end
        end
        ilss_pkg::ST_RESTART: begin
          if (phase == ilss_pkg::PH_HIGH) begin
            res.drive_valid = 1'b1;
            res.drive_byte  = {sensor_address, 1'b1};
            res.bus_command = ilss_pkg::CMD_CONTINUE;
          end else begin
            bad = 1'b1;
          end
        end
        ilss_pkg::ST_SLAW_ACK: begin
          if (phase == ilss_pkg::PH_MODE) begin
            res.drive_valid = 1'b1;
            res.drive_byte  = mode_opcode;
            res.bus_command = ilss_pkg::CMD_CONTINUE;
          end else begin
            bad = 1'b1;
          end
        end
        ilss_pkg::ST_DATA_ACK: begin
          if (phase == ilss_pkg::PH_MODE) begin
            phase_next      = ilss_pkg::PH_HIGH;
            res.bus_command = ilss_pkg::CMD_STOP;
          end else begin
            bad = 1'b1;
          end
        end
        ilss_pkg::ST_DATA_NACK: begin
          bad = (phase != ilss_pkg::PH_HIGH);
        end
        ilss_pkg::ST_SLAR_ACK: begin
          if (phase == ilss_pkg::PH_HIGH) begin
            res.bus_command = ilss_pkg::CMD_ACK;
          end else begin
            bad = 1'b1;
          end
        end
        ilss_pkg::ST_RXDATA_ACK: begin
          if (phase == ilss_pkg::PH_LOW) begin
            phase_next        = ilss_pkg::PH_CLOSE;
            res.bus_command   = ilss_pkg::CMD_STOP;
            res.sample_done   = 1'b1;
            res.led_level     = level;
            res.level_percent = percent;
          end else if (phase == ilss_pkg::PH_HIGH) begin
            high_reading_next = item.rx_byte;
            phase_next        = ilss_pkg::PH_LOW;
            res.bus_command   = ilss_pkg::CMD_ACK;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        sticky_error_next = 1'b1;
      end
    end
    res.error_flag = sticky_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ilss_pkg::PH_MODE;
      sticky_error <= 1'b0;
      high_reading <= '0;
    end else if (adv) begin
      phase        <= phase_next;
      sticky_error <= sticky_error_next;
      high_reading <= high_reading_next;
    end
  end

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    adv && !item.op |=> !sticky_error)
    else $error("begin word did not clear the error");

  a_close_releases: assert property (@(posedge clk) disable iff (rst)
    adv && item.op && phase == ilss_pkg::PH_CLOSE |=> phase == ilss_pkg::PH_MODE)
    else $error("closing event did not return to the first phase");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    res.sample_done |-> res.bus_command == ilss_pkg::CMD_STOP && !bad)
    else $error("sample done without stop");

  a_bad_holds_phase: assert property (@(posedge clk) disable iff (rst)
    adv && bad |=> phase == $past(phase) && sticky_error)
    else $error("rejected status moved the phase");

endmodule

@@ rtl/i2c_light_sensor_read_sequencer.sv @@
// Top level of the light sensor read sequencer: ports, registers, pipeline.
// Takes one word per clock cycle while the master side is not stalled.
// Each word passes an input register and a result register before its
// result word is presented on the master side; all status checking and
// the level arithmetic sit in the one stage between those registers.
// A begin word (tuser low) clears the sticky error; every word yields
// exactly one result word. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module i2c_light_sensor_read_sequencer #(
  parameter logic [ilss_pkg::AddrW-1:0] SENSOR_ADDRESS_RST = ilss_pkg::SENSOR_ADDRESS_RST,
  parameter logic [ilss_pkg::ByteW-1:0] MODE_OPCODE_RST    = ilss_pkg::MODE_OPCODE_RST
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // bus_status[7:0], rx_byte[15:8]
  input  logic [ilss_pkg::InDataW-1:0]   s_tdata,
  // op
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drive_valid[0], drive_byte[8:1], bus_command[11:9], error_flag[12],
  // sample_done[13], led_level[21:14], level_percent[28:22], zero[31:29]
  output logic [ilss_pkg::OutDataW-1:0]  m_tdata,
  input  logic                           cfg_we,
  input  logic [ilss_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ilss_pkg::CfgW-1:0]      cfg_data
);

  logic [ilss_pkg::AddrW-1:0] sensor_address;
  logic [ilss_pkg::ByteW-1:0] mode_opcode;
  logic                       in_valid;
  ilss_pkg::item_t            in_q;
  logic                       out_valid;
  ilss_pkg::result_t          out_q;
  ilss_pkg::result_t          res;
  logic                       adv;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_address <= SENSOR_ADDRESS_RST;
      mode_opcode    <= MODE_OPCODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ilss_pkg::REG_SENSOR_ADDRESS: sensor_address <= cfg_data[ilss_pkg::AddrW-1:0];
        ilss_pkg::REG_MODE_OPCODE:    mode_opcode    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q.op         <= s_tuser;
      in_q.bus_status <= s_tdata[7:0];
      in_q.rx_byte    <= s_tdata[15:8];
    end
  end

  ilss_step u_step (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .item           (in_q),
    .sensor_address (sensor_address),
    .mode_opcode    (mode_opcode),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_q.level_percent, out_q.led_level, out_q.sample_done,
                     out_q.error_flag, out_q.bus_command, out_q.drive_byte,
                     out_q.drive_valid};

endmodule

@@ bench/tb_i2c_light_sensor_read_sequencer.sv @@
// Self-checking bench for the light sensor read sequencer: stream stimulus, scoreboard, watchdog.
module tb_i2c_light_sensor_read_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEM_TARGET    = 1900;
  localparam int NUM_SETTINGS   = 5;

  // m_tdata layout, most significant field first
  typedef struct packed {
    logic [2:0]                 pad;
    logic [ilss_pkg::PctW-1:0]  pct;
    logic [ilss_pkg::ByteW-1:0] level;
    logic                       done;
    logic                       err;
    logic [ilss_pkg::CmdW-1:0]  cmd;
    logic [ilss_pkg::ByteW-1:0] drive;
    logic                       drive_vld;
  } seq_word_t;

  class light_seq_scoreboard;
    logic [ilss_pkg::AddrW-1:0]  addr;
    logic [ilss_pkg::ByteW-1:0]  opcode;
    logic [ilss_pkg::PhaseW-1:0] phase;
    logic                        err;
    logic [ilss_pkg::ByteW-1:0]  hi_byte;
    logic [ilss_pkg::ByteW-1:0]  lo_byte;
    seq_word_t                   pending[$];
    int                          fails;
    int                          words_in;
    int                          samples;
    int                          err_hits;

    function new();
      addr    = ilss_pkg::SENSOR_ADDRESS_RST;
      opcode  = ilss_pkg::MODE_OPCODE_RST;
      phase   = ilss_pkg::PH_MODE;
      err     = 1'b0;
      hi_byte = '0;
      lo_byte = '0;
    endfunction

    function void set_reg(logic [ilss_pkg::CfgIdxW-1:0] idx, logic [ilss_pkg::CfgW-1:0] val);
      if (idx == ilss_pkg::REG_SENSOR_ADDRESS) begin
        addr = val[ilss_pkg::AddrW-1:0];
      end else begin
        opcode = val;
      end
    endfunction

    function logic [ilss_pkg::ByteW-1:0] level_of(logic [ilss_pkg::ByteW-1:0] hi,
                                                  logic [ilss_pkg::ByteW-1:0] lo);
      if (hi == 0 && (lo & ilss_pkg::TOP3_MASK) == 0) return ilss_pkg::LEVEL_DARK;
      if ((hi & ilss_pkg::TOP3_MASK) == 0) return ilss_pkg::LEVEL_DIM;
      return 8'd255 - hi;
    endfunction

    function void note_word(logic op, logic [ilss_pkg::ByteW-1:0] st,
                            logic [ilss_pkg::ByteW-1:0] rx);
      seq_word_t w;
      bit        bad;
      int        lvl;
      int        pct_val;
      w   = '0;
      bad = 0;
      words_in++;
      if (!op) begin
        err = 1'b0;
      end else if (phase == ilss_pkg::PH_CLOSE) begin
        phase = ilss_pkg::PH_MODE;
        w.cmd = ilss_pkg::CMD_RELEASE;
      end else begin
        case (st)
          ilss_pkg::ST_START: begin
            if (phase == ilss_pkg::PH_MODE) begin
              w.drive_vld = 1'b1;
              w.drive     = {addr, 1'b0};
              w.cmd       = ilss_pkg::CMD_CONTINUE;
            end else bad = 1;
          end
          ilss_pkg::ST_RESTART: begin
            if (phase == ilss_pkg::PH_HIGH) begin
              w.drive_vld = 1'b1;
              w.drive     = {addr, 1'b1};
              w.cmd       = ilss_pkg::CMD_CONTINUE;
            end else bad = 1;
          end
          ilss_pkg::ST_SLAW_ACK: begin
            if (phase == ilss_pkg::PH_MODE) begin
              w.drive_vld = 1'b1;
              w.drive     = opcode;
              w.cmd       = ilss_pkg::CMD_CONTINUE;
            end else bad = 1;
          end
          ilss_pkg::ST_DATA_ACK: begin
            if (phase == ilss_pkg::PH_MODE) begin
              phase = ilss_pkg::PH_HIGH;
              w.cmd = ilss_pkg::CMD_STOP;
            end else bad = 1;
          end
          ilss_pkg::ST_DATA_NACK: begin
            if (phase != ilss_pkg::PH_HIGH) bad = 1;
          end
          ilss_pkg::ST_SLAR_ACK: begin
            if (phase == ilss_pkg::PH_HIGH) w.cmd = ilss_pkg::CMD_ACK;
            else bad = 1;
          end
          ilss_pkg::ST_RXDATA_ACK: begin
            if (phase == ilss_pkg::PH_LOW) begin
              lo_byte = rx;
              phase   = ilss_pkg::PH_CLOSE;
              w.cmd   = ilss_pkg::CMD_STOP;
              w.done  = 1'b1;
              w.level = level_of(hi_byte, lo_byte);
              lvl     = int'(w.level);
              pct_val = 100 - 4 * (lvl / 10);
              w.pct   = pct_val[ilss_pkg::PctW-1:0];
              samples++;
            end else if (phase == ilss_pkg::PH_HIGH) begin
              hi_byte = rx;
              phase   = ilss_pkg::PH_LOW;
              w.cmd   = ilss_pkg::CMD_ACK;
            end else bad = 1;
          end
          default: bad = 1;
        endcase
        if (bad) begin
          err = 1'b1;
          err_hits++;
        end
      end
      w.err = err;
      pending.push_back(w);
    endfunction

    function void check_word(logic [ilss_pkg::OutDataW-1:0] data);
      seq_word_t got;
      seq_word_t want;
      got = data;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result word %h", data);
        return;
      end
      want = pending.pop_front();
      if (got.drive_vld !== want.drive_vld || got.drive !== want.drive ||
          got.cmd !== want.cmd || got.err !== want.err || got.done !== want.done ||
          got.level !== want.level || got.pct !== want.pct || got.pad !== want.pad) begin
        fails++;
        if (fails <= 10)
          $display("mismatch exp dv=%0d byte=%h cmd=%0d err=%0d done=%0d lvl=%0d pct=%0d pad=%0d",
                   want.drive_vld, want.drive, want.cmd, want.err, want.done,
                   want.level, want.pct, want.pad,
                   "\n         got dv=%0d byte=%h cmd=%0d err=%0d done=%0d lvl=%0d pct=%0d pad=%0d",
                   got.drive_vld, got.drive, got.cmd, got.err, got.done,
                   got.level, got.pct, got.pad);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ilss_pkg::InDataW-1:0]   s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ilss_pkg::OutDataW-1:0]  m_tdata;
  logic                           cfg_we;
  logic [ilss_pkg::CfgIdxW-1:0]   cfg_index;
  logic [ilss_pkg::CfgW-1:0]      cfg_data;

  light_seq_scoreboard sb;
  bit                  steady;
  int                  sent;
  int                  stall_left;
  int                  idle_cycles;
  int                  settings_used;

  i2c_light_sensor_read_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [ilss_pkg::ByteW-1:0] pick_code();
    case ($urandom_range(0, 6))
      0: return ilss_pkg::ST_START;
      1: return ilss_pkg::ST_RESTART;
      2: return ilss_pkg::ST_SLAW_ACK;
      3: return ilss_pkg::ST_DATA_ACK;
      4: return ilss_pkg::ST_DATA_NACK;
      5: return ilss_pkg::ST_SLAR_ACK;
      default: return ilss_pkg::ST_RXDATA_ACK;
    endcase
  endfunction

  // receiver backpressure
  always @(negedge clk) begin
    if (rst || steady) begin
      m_tready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata[7:0], s_tdata[15:8]);
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("i2c_light_sensor_read_sequencer regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic send_word(logic op, logic [ilss_pkg::ByteW-1:0] st,
                           logic [ilss_pkg::ByteW-1:0] rx);
    int gap;
    gap = (!steady && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {rx, st};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_status(logic [ilss_pkg::ByteW-1:0] st, logic [ilss_pkg::ByteW-1:0] rx,
                             bit noisy);
    if (noisy && $urandom_range(0, 15) == 0) begin
      send_word($urandom_range(0, 5) != 0,
                $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_code(),
                8'($urandom_range(0, 255)));
    end
    send_word(1'b1, st, rx);
  endtask

  // one full two-phase read: mode write, then high and low byte, then bus release
  task automatic run_read(logic [ilss_pkg::ByteW-1:0] hi, logic [ilss_pkg::ByteW-1:0] lo,
                          logic [ilss_pkg::ByteW-1:0] last_st, bit with_begin, bit nack,
                          bit noisy);
    if (with_begin) send_word(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_status(ilss_pkg::ST_START, 8'($urandom_range(0, 255)), noisy);
    send_status(ilss_pkg::ST_SLAW_ACK, 8'($urandom_range(0, 255)), noisy);
    send_status(ilss_pkg::ST_DATA_ACK, 8'($urandom_range(0, 255)), noisy);
    send_status(ilss_pkg::ST_RESTART, 8'($urandom_range(0, 255)), noisy);
    if (nack) send_status(ilss_pkg::ST_DATA_NACK, 8'($urandom_range(0, 255)), noisy);
    send_status(ilss_pkg::ST_SLAR_ACK, 8'($urandom_range(0, 255)), noisy);
    send_status(ilss_pkg::ST_RXDATA_ACK, hi, noisy);
    send_status(ilss_pkg::ST_RXDATA_ACK, lo, noisy);
    send_status(last_st, 8'($urandom_range(0, 255)), noisy);
  endtask

  task automatic settle_bus();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(logic [ilss_pkg::CfgIdxW-1:0] idx,
                                  logic [ilss_pkg::CfgW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    logic [ilss_pkg::ByteW-1:0] hi;
    logic [ilss_pkg::ByteW-1:0] lo;
    int                         phase_end;
    int                         pick;

    sb          = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    steady      = 1'b0;
    sent        = 0;
    stall_left  = 0;
    idle_cycles = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: dark reading with a nack, misplaced statuses, bright reading after a begin
    run_read(8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_word(1'b1, 8'hFF, 8'hFF);
    send_word(1'b1, ilss_pkg::ST_RXDATA_ACK, 8'h00);
    send_word(1'b1, 8'h00, 8'h00);
    run_read(8'hFF, 8'hFF, ilss_pkg::ST_RXDATA_ACK, 1'b1, 1'b0, 1'b0);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      settle_bus();
      case (s)
        0: ;
        1: begin
          program_register(ilss_pkg::REG_SENSOR_ADDRESS, 8'h00);
          program_register(ilss_pkg::REG_MODE_OPCODE, 8'h00);
        end
        2: begin
          program_register(ilss_pkg::REG_SENSOR_ADDRESS, 8'hFF);
          program_register(ilss_pkg::REG_MODE_OPCODE, 8'hFF);
        end
        default: begin
          program_register(ilss_pkg::REG_SENSOR_ADDRESS, 8'($urandom_range(0, 255)));
          program_register(ilss_pkg::REG_MODE_OPCODE, 8'($urandom_range(0, 255)));
        end
      endcase
      settings_used++;
      phase_end = 22 + (ITEM_TARGET - 22) * (s + 1) / NUM_SETTINGS;
      while (sent < phase_end) begin
        steady = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 7);
        case (pick)
          0: hi = 8'h00;
          1: hi = 8'($urandom_range(0, 31));
          2: hi = 8'hFF;
          default: hi = 8'($urandom_range(0, 255));
        endcase
        lo = $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255));
        run_read(hi, lo, 8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
                 $urandom_range(0, 2) == 0, 1'b1);
      end
      steady = 1'b0;
    end

    settle_bus();
    $display("run: %0d words over %0d register settings, %0d light samples taken",
             sb.words_in, settings_used, sb.samples);
    $display("     %0d sequence errors flagged, %0d failures", sb.err_hits, sb.fails);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("i2c_light_sensor_read_sequencer regression: pass");
    end else begin
      $display("i2c_light_sensor_read_sequencer regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ilss_pkg.sv
rtl/ilss_level.sv
rtl/ilss_step.sv
rtl/i2c_light_sensor_read_sequencer.sv
bench/tb_i2c_light_sensor_read_sequencer.sv
